// ===== rtl/address_range_region_table_defines.svh =====
// ----------------------------------------------------------------------------
// address range region table: assertion macros
// shared check forms for the region table, all clocked on clk and held off
// while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_REGION_TABLE_DEFINES_SVH
`define ADDRESS_RANGE_REGION_TABLE_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define ARRT_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence that holds in the cycle after a trigger
`define ARRT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/arrt_pkg.sv =====
// ----------------------------------------------------------------------------
// arrt_pkg
// types, sizes and the priority merge shared by the region table modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arrt_pkg;

	localparam int ENTRIES = 256;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int NPAD    = 1 << IDX_W;
	localparam int LVLS    = IDX_W;
	localparam int ADDR_W  = 32;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	// one candidate in the priority tree
	typedef struct packed {
		logic              hit;
		logic              chit;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] base;
	} leaf_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic             add;
		logic             look;
		logic             upd;
		logic [IDX_W-1:0] win_idx;
	} cell_ctl_t;

	// cached hit wins, then the lower index among plain hits
	function automatic leaf_t leaf_pick(input leaf_t lo, input leaf_t hi);
		leaf_t r;
		if (hi.chit)
			r = hi;
		else if (lo.chit || lo.hit)
			r = lo;
		else
			r = hi;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/address_range_region_table.sv =====
// ----------------------------------------------------------------------------
// address_range_region_table
// table of address regions with append and first-match lookup behind a
// one-entry last-hit cache
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low. An
// append's result strobes on done in the next cycle, and busy stays low, so
// a new item can follow at once. A lookup compares the address against
// every slot in parallel in the cycle it is taken, then walks a registered
// priority tree of log2(ENTRIES) levels; busy is high until its result
// strobes on done, so no new item is taken while a lookup is under way.
// Results are shown for a single cycle with done high and cannot be held
// off: the receiver must take them as they come.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module address_range_region_table
	import arrt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [31:0] address,
	input  wire logic [31:0] length,
	output logic             done,
	output logic [1:0]       status,
	output logic [7:0]       region_index,
	output logic [31:0]      region_base,
	output logic [8:0]       fill_count
);

	`include "address_range_region_table_defines.svh"

	localparam int STG_W = $clog2(LVLS + 1);

	typedef enum logic {
		S_IDLE,
		S_SRCH
	} state_t;

	state_t             state_q;
	logic [STG_W-1:0]   stg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	status_t            status_q;
	logic [IDX_W-1:0]   idx_q;
	logic [ADDR_W-1:0]  base_q;
	logic [CNT_W-1:0]   fill_q;

	logic               take;
	logic               full;
	logic               last;
	cell_ctl_t          ctl;
	leaf_t              leaves [ENTRIES];
	leaf_t              root;
	logic [ENTRIES-1:0] tok_w;
	logic [ENTRIES-1:0] cached_w;

	// transfer and broadcast control
	always_comb begin
		take        = start && (state_q == S_IDLE);
		full        = (cnt_q == CNT_W'(ENTRIES));
		last        = (state_q == S_SRCH) && (stg_q == STG_W'(LVLS));
		ctl.add     = take && !action && !full;
		ctl.look    = take && action;
		ctl.upd     = last && root.hit && !root.chit;
		ctl.win_idx = root.idx;
	end

	// row of region cells, token chained from each to the next
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		arrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.my_idx    (IDX_W'(g)),
			.tok_first ((g == 0) ? 1'b1 : 1'b0),
			.tok_in    ((g == 0) ? 1'b0 : tok_w[(g == 0) ? 0 : g-1]),
			.ctl       (ctl),
			.cnt       (cnt_q),
			.address   (address),
			.length    (length),
			.tok       (tok_w[g]),
			.cached    (cached_w[g]),
			.leaf      (leaves[g])
		);
	end

	arrt_pick u_pick (
		.clk    (clk),
		.leaves (leaves),
		.root   (root)
	);

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			stg_q    <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			idx_q    <= '0;
			base_q   <= '0;
			fill_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take && !action) begin
						done_q <= 1'b1;
						if (full) begin
							status_q <= ST_FULL;
							idx_q    <= '0;
							base_q   <= '0;
							fill_q   <= cnt_q;
						end else begin
							status_q <= ST_OK;
							idx_q    <= cnt_q[IDX_W-1:0];
							base_q   <= address;
							fill_q   <= cnt_q + CNT_W'(1);
							cnt_q    <= cnt_q + CNT_W'(1);
						end
					end else if (take) begin
						state_q <= S_SRCH;
						stg_q   <= '0;
					end
				end
				S_SRCH: begin
					stg_q <= stg_q + STG_W'(1);
					if (last) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						fill_q  <= cnt_q;
						if (root.hit) begin
							status_q <= ST_OK;
							idx_q    <= root.idx;
							base_q   <= root.base;
						end else begin
							status_q <= ST_MISS;
							idx_q    <= '0;
							base_q   <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign region_index = 8'(idx_q);
	assign region_base  = base_q;
	assign fill_count   = 9'(fill_q);

	// checks on the token row, the cache mark and the sequencer
	`ARRT_CHECK(a_tok_onehot, $onehot0(tok_w), "write token held by more than one cell")
	`ARRT_CHECK(a_tok_full, (tok_w == '0) == full, "write token disagrees with fill count")
	`ARRT_CHECK(a_cache_onehot, $onehot0(cached_w), "more than one cell marked as last hit")
	`ARRT_NEXT(a_look_busy, take && action, busy && !done, "lookup transfer did not start search")
	`ARRT_NEXT(a_full_keep, take && !action && full, fill_count == 9'(ENTRIES) && done,
		"append to full table changed the count")

endmodule

`default_nettype wire

// ===== rtl/arrt_cell.sv =====
// ----------------------------------------------------------------------------
// arrt_cell
// one region slot: holds base and size, the write token handed along the
// row, the last-hit mark, and registers its own range compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arrt_cell
	import arrt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [IDX_W-1:0]  my_idx,
	input  wire logic              tok_first,
	input  wire logic              tok_in,
	input  wire cell_ctl_t         ctl,
	input  wire logic [CNT_W-1:0]  cnt,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic [ADDR_W-1:0] length,
	output logic                   tok,
	output logic                   cached,
	output leaf_t                  leaf
);

	logic              tok_q;
	logic              cached_q;
	logic              hit_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] size_q;
	logic              used;
	logic [ADDR_W:0]   end_w;
	logic              in_rng;

	// range test with the end kept at 33 bits
	always_comb begin
		used   = CNT_W'(my_idx) < cnt;
		end_w  = {1'b0, base_q} + {1'b0, size_q};
		in_rng = used && (address >= base_q) && ({1'b0, address} < end_w);
	end

	// write token moves one cell down the row on every append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= tok_first;
			cached_q <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			if (ctl.add)
				tok_q <= tok_in;
			if (ctl.upd)
				cached_q <= (my_idx == ctl.win_idx);
			if (ctl.look)
				hit_q <= in_rng;
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (ctl.add && tok_q) begin
			base_q <= address;
			size_q <= length;
		end
	end

	assign tok    = tok_q;
	assign cached = cached_q;

	always_comb begin
		leaf.hit  = hit_q;
		leaf.chit = hit_q & cached_q;
		leaf.idx  = my_idx;
		leaf.base = base_q;
	end

endmodule

`default_nettype wire

// ===== rtl/arrt_pick.sv =====
// ----------------------------------------------------------------------------
// arrt_pick
// registered binary priority tree over the cell compare results, one level
// per cycle, cached hit first and lowest index next
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arrt_pick
	import arrt_pkg::*;
(
	input  wire logic  clk,
	input  wire leaf_t leaves [ENTRIES],
	output leaf_t      root
);

	leaf_t pad [NPAD];
	leaf_t nd_q [LVLS][NPAD/2];

	// unused leaves never hit
	always_comb begin
		for (int j = 0; j < NPAD; j++) begin
			if (j < ENTRIES)
				pad[j] = leaves[j];
			else
				pad[j] = '0;
		end
	end

	// one merge level per register stage
	always_ff @(posedge clk) begin
		for (int j = 0; j < NPAD/2; j++)
			nd_q[0][j] <= leaf_pick(pad[2*j], pad[2*j+1]);
		for (int l = 1; l < LVLS; l++) begin
			for (int j = 0; j < (NPAD >> (l + 1)); j++)
				nd_q[l][j] <= leaf_pick(nd_q[l-1][2*j], nd_q[l-1][2*j+1]);
			for (int j = (NPAD >> (l + 1)); j < NPAD/2; j++)
				nd_q[l][j] <= '0;
		end
	end

	assign root = nd_q[LVLS-1][0];

endmodule

`default_nettype wire

// ===== verif/address_range_region_table_tb.sv =====
// ----------------------------------------------------------------------------
// address_range_region_table_tb
// self-checking bench for the region table: directed corner cases, then
// bursty random appends and lookups checked against an in-bench predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module address_range_region_table_tb;
	import arrt_pkg::*;

	localparam logic ACT_ADD      = 1'b0;
	localparam logic ACT_FIND     = 1'b1;
	localparam int   RANDOM_ITEMS = 1780;
	localparam int   DRAIN_EVERY  = 450;
	localparam int   TAIL_CYCLES  = 4 * (IDX_W + 2);
	localparam int   DRAIN_LIMIT  = 5000;

	// predicts append and lookup results and keeps the results still owed
	class region_table_scoreboard;
		typedef struct {
			status_t          st;
			logic [IDX_W-1:0] idx;
			logic [31:0]      base;
			logic [CNT_W-1:0] fill;
		} region_result_t;

		logic [31:0]    base_tab [ENTRIES];
		logic [31:0]    size_tab [ENTRIES];
		int unsigned    fill;
		int unsigned    last_hit;
		bit             last_hit_ok;
		int             errors;
		region_result_t pending_results [$];

		// region end taken at 33 bits so it never wraps
		function bit holds(int unsigned k, logic [31:0] a);
			logic [32:0] lo;
			logic [32:0] hi;
			lo = {1'b0, base_tab[k]};
			hi = lo + {1'b0, size_tab[k]};
			return ({1'b0, a} >= lo) && ({1'b0, a} < hi);
		endfunction

		// one accepted transfer: update the table and queue its result
		function void note_transfer(logic act, logic [31:0] addr, logic [31:0] len);
			region_result_t r;
			bit             found;
			r.st   = ST_MISS;
			r.idx  = '0;
			r.base = '0;
			found  = 1'b0;
			if (act == ACT_ADD) begin
				if (fill >= ENTRIES) begin
					r.st = ST_FULL;
				end else begin
					base_tab[fill] = addr;
					size_tab[fill] = len;
					r.st   = ST_OK;
					r.idx  = IDX_W'(fill);
					r.base = addr;
					fill++;
				end
			end else if (last_hit_ok && last_hit < fill && holds(last_hit, addr)) begin
				// last hit is tried before the scan
				r.st   = ST_OK;
				r.idx  = IDX_W'(last_hit);
				r.base = base_tab[last_hit];
			end else begin
				// lowest index wins; a miss leaves the last hit alone
				for (int unsigned k = 0; k < fill && !found; k++) begin
					if (holds(k, addr)) begin
						found       = 1'b1;
						last_hit    = k;
						last_hit_ok = 1'b1;
						r.st        = ST_OK;
						r.idx       = IDX_W'(k);
						r.base      = base_tab[k];
					end
				end
			end
			r.fill = CNT_W'(fill);
			pending_results.push_back(r);
		endfunction

		function void compare_field(string label, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
			end
		endfunction

		// one result strobe against the oldest owed result
		function void check_result(logic [1:0] st, logic [IDX_W-1:0] idx, logic [31:0] base,
				logic [CNT_W-1:0] cnt);
			region_result_t e;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual status %0d index %0d base %h fill %0d",
					$time, st, idx, base, cnt);
				return;
			end
			e = pending_results.pop_front();
			compare_field("status", 32'(e.st), 32'(st));
			compare_field("region_index", 32'(e.idx), 32'(idx));
			compare_field("region_base", e.base, base);
			compare_field("fill_count", 32'(e.fill), 32'(cnt));
		endfunction
	endclass

	logic                   clk     = 1'b0;
	logic                   arst_n  = 1'b0;
	logic                   start   = 1'b0;
	logic                   action  = 1'b0;
	logic [31:0]            address = '0;
	logic [31:0]            length  = '0;
	logic                   busy;
	logic                   done;
	logic [1:0]             status;
	logic [7:0]             region_index;
	logic [31:0]            region_base;
	logic [8:0]             fill_count;

	region_table_scoreboard sb;
	int                     burst_left = 0;

	address_range_region_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.address      (address),
		.length       (length),
		.done         (done),
		.status       (status),
		.region_index (region_index),
		.region_base  (region_base),
		.fill_count   (fill_count)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, region_index, region_base, fill_count);
	end

	// one transfer, with a random gap first when the current burst is used up
	task automatic issue(logic act, logic [31:0] addr, logic [31:0] len);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		start   <= 1'b1;
		action  <= act;
		address <= addr;
		length  <= len;
		do @(posedge clk); while (busy);
		sb.note_transfer(act, addr, len);
	endtask

	// hold off until every owed result has come back
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin
		int          roll;
		int          pick;
		int unsigned slot;
		int          waited;
		logic [31:0] addr;
		logic [31:0] len;
		logic [31:0] lo;
		logic [32:0] span;

		sb = new();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// lookups on an empty table
		issue(ACT_FIND, 32'h0000_0000, 32'h0000_0000);
		issue(ACT_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// two overlapping regions: region 0 gets cached, then the cache beats a lower index
		issue(ACT_ADD, 32'h0000_1000, 32'h0000_1000);
		issue(ACT_ADD, 32'h0000_1800, 32'h0000_1000);
		issue(ACT_FIND, 32'h0000_1FFF, 32'h0);
		issue(ACT_FIND, 32'h0000_1800, 32'h0);
		issue(ACT_FIND, 32'h0000_2000, 32'h0);
		issue(ACT_FIND, 32'h0000_1900, 32'h0);
		issue(ACT_FIND, 32'h0000_27FF, 32'h0);
		// a miss keeps the cached region
		issue(ACT_FIND, 32'h0000_2800, 32'h0);
		issue(ACT_FIND, 32'h0000_1C00, 32'h0);
		issue(ACT_FIND, 32'h0000_0FFF, 32'h0);
		// zero-size region never matches
		issue(ACT_ADD, 32'h8000_0000, 32'h0000_0000);
		issue(ACT_FIND, 32'h8000_0000, 32'h0);
		// regions whose end runs past the 32-bit range
		issue(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(ACT_FIND, 32'hFFFF_FFFF, 32'h0);
		issue(ACT_ADD, 32'hFFFF_0000, 32'hFFFF_FFFF);
		issue(ACT_FIND, 32'hFFFF_FFFE, 32'h0);
		issue(ACT_FIND, 32'hFFFF_FFFF, 32'h0);
		// one-byte region at address zero
		issue(ACT_ADD, 32'h0000_0000, 32'h0000_0001);
		issue(ACT_FIND, 32'h0000_0000, 32'h0);
		issue(ACT_FIND, 32'h0000_0001, 32'h0);
		drain_results();

		// random appends and lookups, mostly aimed at stored regions
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
				drain_results();
			roll = $urandom_range(0, 99);
			if (roll < ((sb.fill < ENTRIES) ? 30 : 8)) begin
				pick = $urandom_range(0, 99);
				if (pick < 8)
					len = '0;
				else if (pick < 68)
					len = $urandom_range(1, 4096);
				else if (pick < 90)
					len = $urandom_range(1, 32'h0010_0000);
				else if (pick < 98)
					len = $urandom & 32'h00FF_FFFF;
				else
					len = $urandom & 32'h0FFF_FFFF;
				issue(ACT_ADD, $urandom, len);
			end else begin
				pick = $urandom_range(0, 99);
				addr = $urandom;
				if (sb.fill != 0 && pick < 80) begin
					slot = $urandom_range(0, sb.fill - 1);
					lo   = sb.base_tab[slot];
					span = 33'h1_0000_0000 - {1'b0, lo};
					if ({1'b0, sb.size_tab[slot]} < span)
						span = {1'b0, sb.size_tab[slot]};
					if (pick < 65 && span != 0)
						addr = lo + $urandom_range(0, 32'(span - 1));
					else if (pick < 72)
						addr = lo - 32'd1;
					else
						addr = lo + sb.size_tab[slot];
				end
				issue(ACT_FIND, addr, $urandom);
			end
		end

		// let the last results come back, then a short quiet tail
		@(negedge clk);
		start <= 1'b0;
		waited = 0;
		while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// run limit
	initial begin
		#10ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== address_range_region_table.f =====
+incdir+rtl
rtl/arrt_pkg.sv
rtl/arrt_cell.sv
rtl/arrt_pick.sv
rtl/address_range_region_table.sv
verif/address_range_region_table_tb.sv
